### hdl/mb3d_pkg.sv
// ----------------------------------------------------------------------------
// mb3d_pkg: shared types and constants for the 3D Morton BIGMIN search
// Decision codes for the (code, min, max) bit triple and the status that
// rides along the cell chain with each item.
// ----------------------------------------------------------------------------
package mb3d_pkg;

   localparam int AXIS_BITS_DEFAULT = 10;
   localparam int AXES              = 3;

   // Triple codes, ordered {code bit, min bit, max bit}
   localparam logic [2:0] TRIP_SPLIT    = 3'b001;
   localparam logic [2:0] TRIP_RAISE    = 3'b101;
   localparam logic [2:0] TRIP_TAKE_MIN = 3'b011;
   localparam logic [2:0] TRIP_TAKE_CND = 3'b100;
   localparam logic [2:0] TRIP_BAD_LO   = 3'b010;
   localparam logic [2:0] TRIP_BAD_HI   = 3'b110;

   typedef struct packed {
      logic valid;
      logic done;
      logic bad;
   } stat_type;

endpackage

### hdl/mb3d_cell.sv
// ----------------------------------------------------------------------------
// mb3d_cell: one bit position of the BIGMIN scan
// Applies the decision table at bit BIT to the item it holds and registers
// the updated min, max and candidate for the next cell down the chain.
// ----------------------------------------------------------------------------
module mb3d_cell #(
   parameter int CODE_BITS = 3 * mb3d_pkg::AXIS_BITS_DEFAULT,
   parameter int BIT       = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [CODE_BITS-1:0]    in_code,
   input  logic [CODE_BITS-1:0]    in_lo,
   input  logic [CODE_BITS-1:0]    in_hi,
   input  logic [CODE_BITS-1:0]    in_cand,
   input  mb3d_pkg::stat_type      in_stat,
   output logic [CODE_BITS-1:0]    out_code,
   output logic [CODE_BITS-1:0]    out_lo,
   output logic [CODE_BITS-1:0]    out_hi,
   output logic [CODE_BITS-1:0]    out_cand,
   output mb3d_pkg::stat_type      out_stat
);

   localparam logic [CODE_BITS-1:0] BIT_MASK = {{(CODE_BITS-1){1'b0}}, 1'b1} << BIT;

   logic [CODE_BITS-1:0] below_mask;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [CODE_BITS-1:0] lo_ff, lo_in;
   logic [CODE_BITS-1:0] hi_ff, hi_in;
   logic [CODE_BITS-1:0] cand_ff, cand_in;
   mb3d_pkg::stat_type   stat_ff, stat_in;
   logic [2:0]           trip;

   // lower bits of the same axis as BIT
   for (genvar j = 0; j < CODE_BITS; j++) begin : g_below
      assign below_mask[j] = (j < BIT) && ((j % mb3d_pkg::AXES) == (BIT % mb3d_pkg::AXES));
   end

   assign trip = {in_code[BIT], in_lo[BIT], in_hi[BIT]};

   always_comb begin
      code_in = in_code;
      lo_in   = in_lo;
      hi_in   = in_hi;
      cand_in = in_cand;
      stat_in = in_stat;
      // a finished item passes through untouched
      if (!in_stat.done) begin
         case (trip)
            mb3d_pkg::TRIP_SPLIT: begin
               cand_in = (in_lo & ~below_mask) | BIT_MASK;
               hi_in   = (in_hi | below_mask) & ~BIT_MASK;
            end
            mb3d_pkg::TRIP_RAISE: begin
               lo_in = (in_lo & ~below_mask) | BIT_MASK;
            end
            mb3d_pkg::TRIP_TAKE_MIN: begin
               cand_in      = in_lo;
               stat_in.done = 1'b1;
            end
            mb3d_pkg::TRIP_TAKE_CND: begin
               stat_in.done = 1'b1;
            end
            mb3d_pkg::TRIP_BAD_LO, mb3d_pkg::TRIP_BAD_HI: begin
               stat_in.bad = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (advance) begin
         stat_ff <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         code_ff <= code_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cand_ff <= cand_in;
      end
   end

   assign out_code = code_ff;
   assign out_lo   = lo_ff;
   assign out_hi   = hi_ff;
   assign out_cand = cand_ff;
   assign out_stat = stat_ff;

endmodule

### hdl/morton3d_bigmin.sv
// ----------------------------------------------------------------------------
// morton3d_bigmin: BIGMIN search for 3D Morton codes
// Returns the smallest code inside a query box above a given code.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one query item: code, box_min, box_max (Morton codes).
//   rsp channel returns one item per query: next_code and bad_range.
//   Each bit position is a cell in a chain of 3*AXIS_BITS registered cells,
//   top bit first; the last cell's registers drive the rsp channel.
//   Throughput: one item per cycle while the receiver does not stall, set by the single-stage cells.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   req_tready drops; items in flight keep their order and none are lost.
//   While the last cell is empty the chain keeps moving and req_tready is high.
//   Reset clears all item valid flags; no result is presented after reset
//   until a query has gone through the chain.
// ----------------------------------------------------------------------------
module morton3d_bigmin #(
   parameter int AXIS_BITS = mb3d_pkg::AXIS_BITS_DEFAULT,
   parameter int CODE_BITS = mb3d_pkg::AXES * AXIS_BITS,
   parameter int REQ_W     = ((3 * CODE_BITS + 7) / 8) * 8,
   parameter int RSP_W     = ((CODE_BITS + 1 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // code, box_min, box_max, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // next_code, bad_range, zero pad
);

   logic [CODE_BITS-1:0] code_w [0:CODE_BITS];
   logic [CODE_BITS-1:0] lo_w   [0:CODE_BITS];
   logic [CODE_BITS-1:0] hi_w   [0:CODE_BITS];
   logic [CODE_BITS-1:0] cand_w [0:CODE_BITS];
   mb3d_pkg::stat_type   stat_w [0:CODE_BITS];
   logic                 advance;

   // move the chain unless a finished result is waiting on the receiver
   assign advance    = !stat_w[CODE_BITS].valid || rsp_tready;
   assign req_tready = advance;

   assign code_w[0]       = req_tdata[CODE_BITS-1:0];
   assign lo_w[0]         = req_tdata[2*CODE_BITS-1:CODE_BITS];
   assign hi_w[0]         = req_tdata[3*CODE_BITS-1:2*CODE_BITS];
   assign cand_w[0]       = '0;
   assign stat_w[0].valid = req_tvalid;
   assign stat_w[0].done  = 1'b0;
   assign stat_w[0].bad   = 1'b0;

   for (genvar k = 0; k < CODE_BITS; k++) begin : g_cell
      mb3d_cell #(
         .CODE_BITS (CODE_BITS),
         .BIT       (CODE_BITS - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_code  (code_w[k]),
         .in_lo    (lo_w[k]),
         .in_hi    (hi_w[k]),
         .in_cand  (cand_w[k]),
         .in_stat  (stat_w[k]),
         .out_code (code_w[k+1]),
         .out_lo   (lo_w[k+1]),
         .out_hi   (hi_w[k+1]),
         .out_cand (cand_w[k+1]),
         .out_stat (stat_w[k+1])
      );
   end

   assign rsp_tvalid = stat_w[CODE_BITS].valid;
   assign rsp_tdata  = RSP_W'({stat_w[CODE_BITS].bad, cand_w[CODE_BITS]});

   // an empty output stage must never block new items
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output stage");

   // a stalled result must freeze the intake as well
   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("intake open while result stalled");

   // reset empties the chain
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

endmodule
